// ===== src/pms_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pms_pkg;

    // Received word kinds
    localparam logic [1:0] OP_TICK      = 2'd0;
    localparam logic [1:0] OP_E2E_REQ   = 2'd1;
    localparam logic [1:0] OP_PEER_RESP = 2'd2;
    localparam logic [1:0] OP_PEER_FUP  = 2'd3;

    // Delay mechanism; any other code leaves the port disabled
    localparam logic [1:0] MODE_OFF = 2'd0;
    localparam logic [1:0] MODE_E2E = 2'd1;
    localparam logic [1:0] MODE_P2P = 2'd2;

    // Peer slave states
    localparam logic [1:0] PEER_NONE        = 2'd0;
    localparam logic [1:0] PEER_CANDIDATE   = 2'd1;
    localparam logic [1:0] PEER_ESTABLISHED = 2'd2;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE          = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_PERIOD   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ANN_PERIOD    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PDELAY_PERIOD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_GATE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DROPOUT       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_QUAL          = 3'd7;

    localparam int unsigned DEF_OWN_PORT_NUMBER = 1;

    typedef struct packed {
        logic [1:0]  op;
        logic [63:0] sender_clock_identity;
        logic [63:0] requester_clock_identity;
        logic [15:0] requester_port;
        logic [15:0] sequence_number;
        logic        twostep;
        logic        request_timestamp_ready;
    } t_item;

    // Transmit requests from the period timers
    typedef struct packed {
        logic        send_pd_request;
        logic [15:0] pdelay_sequence;
        logic        send_sync;
        logic [15:0] sync_sequence;
        logic        send_announce;
        logic [15:0] announce_sequence;
    } t_sched;

    // Outcome of received message handling and peer tracking
    typedef struct packed {
        logic       send_dly_response;
        logic [1:0] slave_state;
        logic       path_delay_due;
        logic       one_step_response;
        logic       accepted;
    } t_peer;

endpackage

`default_nettype wire

// ===== src/pms_item_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface pms_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [63:0] sender_clock_identity;
    logic [63:0] requester_clock_identity;
    logic [15:0] requester_port;
    logic [15:0] sequence_number;
    logic        twostep;
    logic        request_timestamp_ready;

    modport source (
        output valid, op, sender_clock_identity, requester_clock_identity,
               requester_port, sequence_number, twostep, request_timestamp_ready,
        input  ready
    );
    modport sink (
        input  valid, op, sender_clock_identity, requester_clock_identity,
               requester_port, sequence_number, twostep, request_timestamp_ready,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/pms_result_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface pms_result_if;
    logic        valid;
    logic        ready;
    logic        send_pd_request;
    logic [15:0] pdelay_sequence;
    logic        send_sync;
    logic [15:0] sync_sequence;
    logic        send_announce;
    logic [15:0] announce_sequence;
    logic        send_dly_response;
    logic [1:0]  slave_state;
    logic        path_delay_due;
    logic        one_step_response;
    logic        accepted;

    modport source (
        output valid, send_pd_request, pdelay_sequence, send_sync, sync_sequence,
               send_announce, announce_sequence, send_dly_response, slave_state,
               path_delay_due, one_step_response, accepted,
        input  ready
    );
    modport sink (
        input  valid, send_pd_request, pdelay_sequence, send_sync, sync_sequence,
               send_announce, announce_sequence, send_dly_response, slave_state,
               path_delay_due, one_step_response, accepted,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/pms_cfg_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface pms_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/pms_tick_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pms_tick_unit
    import pms_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_adv,
    input  wire logic        i_tick_en,
    input  wire logic        i_p2p,
    input  wire logic        i_gate,
    input  wire logic        i_est_next,
    input  wire logic [15:0] i_sync_period,
    input  wire logic [15:0] i_ann_period,
    input  wire logic [15:0] i_pd_period,
    output logic             o_pd_fire,
    output logic [15:0]      o_pd_seq_cur,
    output t_sched           o_sched
);

    logic [15:0] r_pd_tmr,  n_pd_tmr;
    logic [15:0] r_sy_tmr,  n_sy_tmr;
    logic [15:0] r_an_tmr,  n_an_tmr;
    logic [15:0] r_pd_seq,  n_pd_seq;
    logic [15:0] r_sy_seq,  n_sy_seq;
    logic [15:0] r_an_seq,  n_an_seq;

    logic [16:0] pd_inc, sy_inc, an_inc;
    logic        info_en, sy_fire, an_fire;

    assign pd_inc = {1'b0, r_pd_tmr} + 17'd1;
    assign sy_inc = {1'b0, r_sy_tmr} + 17'd1;
    assign an_inc = {1'b0, r_an_tmr} + 17'd1;

    assign o_pd_fire = i_tick_en && i_p2p && (pd_inc >= {1'b0, i_pd_period});

    always_comb begin
        // gate Sync/Announce on the peer state after this tick's aging
        info_en   = i_tick_en && (!i_p2p || i_est_next || !i_gate);
        sy_fire   = info_en && (sy_inc >= {1'b0, i_sync_period});
        an_fire   = info_en && (an_inc >= {1'b0, i_ann_period});

        n_pd_tmr = r_pd_tmr;
        n_sy_tmr = r_sy_tmr;
        n_an_tmr = r_an_tmr;
        n_pd_seq = r_pd_seq;
        n_sy_seq = r_sy_seq;
        n_an_seq = r_an_seq;

        if (i_tick_en && i_p2p) begin
            n_pd_tmr = o_pd_fire ? 16'd0 : pd_inc[15:0];
        end
        if (o_pd_fire) begin
            n_pd_seq = r_pd_seq + 16'd1;
        end
        if (info_en) begin
            n_sy_tmr = sy_fire ? 16'd0 : sy_inc[15:0];
            n_an_tmr = an_fire ? 16'd0 : an_inc[15:0];
        end
        if (sy_fire) begin
            n_sy_seq = r_sy_seq + 16'd1;
        end
        if (an_fire) begin
            n_an_seq = r_an_seq + 16'd1;
        end

        o_sched.send_pd_request   = o_pd_fire;
        o_sched.pdelay_sequence   = n_pd_seq;
        o_sched.send_sync         = sy_fire;
        o_sched.sync_sequence     = sy_fire ? r_sy_seq : 16'd0;
        o_sched.send_announce     = an_fire;
        o_sched.announce_sequence = an_fire ? r_an_seq : 16'd0;
    end

    assign o_pd_seq_cur = r_pd_seq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pd_tmr <= '0;
            r_sy_tmr <= '0;
            r_an_tmr <= '0;
            r_pd_seq <= '0;
            r_sy_seq <= '0;
            r_an_seq <= '0;
        end else if (i_adv) begin
            r_pd_tmr <= n_pd_tmr;
            r_sy_tmr <= n_sy_tmr;
            r_an_tmr <= n_an_tmr;
            r_pd_seq <= n_pd_seq;
            r_sy_seq <= n_sy_seq;
            r_an_seq <= n_an_seq;
        end
    end

endmodule

`default_nettype wire

// ===== src/pms_peer_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pms_peer_unit
    import pms_pkg::*;
#(
    parameter int unsigned OWN_PORT_NUMBER = DEF_OWN_PORT_NUMBER
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_adv,
    input  wire logic        i_pd_fire,
    input  wire logic        i_e2e,
    input  wire logic        i_p2p,
    input  wire t_item       i_item,
    input  wire logic [15:0] i_pd_seq,
    input  wire logic [63:0] i_own_id,
    input  wire logic [7:0]  i_reload,
    input  wire logic [7:0]  i_qual,
    output logic             o_est_next,
    output t_peer            o_peer
);

    localparam logic [15:0] PORT_NUM = OWN_PORT_NUMBER[15:0];

    logic [1:0]  r_state, n_state;
    logic [63:0] r_id,    n_id;
    logic [7:0]  r_drop,  n_drop;
    logic [8:0]  r_tally, n_tally;
    logic        r_await, n_await;

    logic        match, report;
    logic [7:0]  drop_dec;
    logic [8:0]  cap, inc;

    always_comb begin
        n_state = r_state;
        n_id    = r_id;
        n_drop  = r_drop;
        n_tally = r_tally;
        n_await = r_await;
        report  = 1'b0;
        o_peer  = '0;

        cap      = {1'b0, i_qual} + 9'd1;
        inc      = r_tally + 9'd1;
        drop_dec = (r_drop == 8'd0) ? 8'd0 : r_drop - 8'd1;

        match = i_p2p
             && ((i_item.op == OP_PEER_RESP && i_item.request_timestamp_ready)
                 || i_item.op == OP_PEER_FUP)
             && (i_item.requester_clock_identity == i_own_id)
             && (i_item.requester_port == PORT_NUM)
             && (i_item.sequence_number == i_pd_seq);

        // age the peer once per PDelay period
        if (i_pd_fire) begin
            n_drop = drop_dec;
            if (drop_dec == 8'd0) begin
                n_state = PEER_NONE;
                n_id    = '0;
            end
        end

        if (i_e2e && i_item.op == OP_E2E_REQ) begin
            o_peer.send_dly_response = 1'b1;
            o_peer.accepted          = 1'b1;
        end

        if (match && i_item.op == OP_PEER_RESP) begin
            o_peer.accepted = 1'b1;
            if (i_item.twostep) begin
                n_await = 1'b1;
            end else begin
                report = 1'b1;
            end
        end
        if (match && i_item.op == OP_PEER_FUP && r_await) begin
            o_peer.accepted       = 1'b1;
            o_peer.path_delay_due = (r_state != PEER_NONE);
            n_await               = 1'b0;
            report                = 1'b1;
        end

        if (report) begin
            if (r_state == PEER_NONE) begin
                n_tally = '0;
                n_drop  = i_reload;
                n_id    = i_item.sender_clock_identity;
                n_state = PEER_CANDIDATE;
            end else if (r_id == i_item.sender_clock_identity) begin
                n_drop  = i_reload;
                n_tally = (inc < cap) ? inc : cap;
                if (n_tally > {1'b0, i_qual}) begin
                    n_state = PEER_ESTABLISHED;
                end
            end else begin
                n_state = PEER_NONE;
                n_id    = '0;
                n_drop  = '0;
                n_tally = '0;
            end
        end

        if (match && i_item.op == OP_PEER_RESP && !i_item.twostep) begin
            o_peer.path_delay_due    = (n_state != PEER_NONE);
            o_peer.one_step_response = (n_state != PEER_NONE);
        end

        o_peer.slave_state = n_state;
        o_est_next         = (n_state == PEER_ESTABLISHED);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= PEER_NONE;
            r_id    <= '0;
            r_drop  <= '0;
            r_tally <= '0;
            r_await <= 1'b0;
        end else if (i_adv) begin
            r_state <= n_state;
            r_id    <= n_id;
            r_drop  <= n_drop;
            r_tally <= n_tally;
            r_await <= n_await;
        end
    end

endmodule

`default_nettype wire

// ===== src/ptp_master_message_scheduler_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// PTP master port scheduler, control side. Each word on i_item is either a
// heartbeat tick or a received delay message (end-to-end delay request,
// peer delay response or its follow-up); each one yields exactly one result
// word on o_result carrying the transmit requests (peer delay request, Sync,
// Announce, delay response) with their sequence ids, the peer slave state
// after the word, and the path-delay / acceptance flags. A word is
// registered on entry and resolved into the result register when that
// register is free or being taken, so one word is taken every cycle
// while results are taken; the state update (timers, sequence counters,
// peer tracker) is made as the word advances and sets that rate. One new
// word can enter while a result waits to be taken. Configuration writes on
// i_cfg take effect at once and do not clear timers or peer state; write
// them only while no word is in flight.
module ptp_master_message_scheduler_core
    import pms_pkg::*;
#(
    parameter int unsigned OWN_PORT_NUMBER = DEF_OWN_PORT_NUMBER
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    pms_item_if.sink     i_item,
    pms_cfg_if.sink      i_cfg,
    pms_result_if.source o_result
);

    // configuration registers
    logic [1:0]  r_mode;
    logic [15:0] r_sync_period;
    logic [15:0] r_ann_period;
    logic [15:0] r_pd_period;
    logic        r_gate;
    logic [63:0] r_own_id;
    logic [7:0]  r_reload;
    logic [7:0]  r_qual;

    // input register
    logic  r_iv;
    t_item r_in;

    // result register
    logic   r_ov;
    t_sched r_sched;
    t_peer  r_peer;

    logic        adv, e2e, p2p, tick_en, pd_fire, est_next;
    logic [15:0] pd_seq_cur;
    t_sched      sched;
    t_peer       peer;

    // advance the held word whenever the result slot is free or draining
    assign adv     = r_iv && (!r_ov || o_result.ready);
    assign e2e     = (r_mode == MODE_E2E);
    assign p2p     = (r_mode == MODE_P2P);
    assign tick_en = (r_in.op == OP_TICK) && (e2e || p2p);

    assign i_item.ready = !r_iv || adv;
    assign i_cfg.ready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_OFF;
            r_sync_period <= 16'd1;
            r_ann_period  <= 16'd1;
            r_pd_period   <= 16'd1;
            r_gate        <= 1'b0;
            r_own_id      <= '0;
            r_reload      <= 8'd3;
            r_qual        <= 8'd3;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_MODE:          r_mode        <= i_cfg.data[1:0];
                CFG_SYNC_PERIOD:   r_sync_period <= i_cfg.data[15:0];
                CFG_ANN_PERIOD:    r_ann_period  <= i_cfg.data[15:0];
                CFG_PDELAY_PERIOD: r_pd_period   <= i_cfg.data[15:0];
                CFG_SYNC_GATE:     r_gate        <= i_cfg.data[0];
                CFG_OWN_ID:        r_own_id      <= i_cfg.data;
                CFG_DROPOUT:       r_reload      <= i_cfg.data[7:0];
                CFG_QUAL:          r_qual        <= i_cfg.data[7:0];
                default: begin
                end
            endcase
        end
    end

    // capture the incoming word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= 1'b0;
        end else if (i_item.ready) begin
            r_iv <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in.op                       <= i_item.op;
            r_in.sender_clock_identity    <= i_item.sender_clock_identity;
            r_in.requester_clock_identity <= i_item.requester_clock_identity;
            r_in.requester_port           <= i_item.requester_port;
            r_in.sequence_number          <= i_item.sequence_number;
            r_in.twostep                  <= i_item.twostep;
            r_in.request_timestamp_ready  <= i_item.request_timestamp_ready;
        end
    end

    pms_tick_unit u_tick (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (adv),
        .i_tick_en     (tick_en),
        .i_p2p         (p2p),
        .i_gate        (r_gate),
        .i_est_next    (est_next),
        .i_sync_period (r_sync_period),
        .i_ann_period  (r_ann_period),
        .i_pd_period   (r_pd_period),
        .o_pd_fire     (pd_fire),
        .o_pd_seq_cur  (pd_seq_cur),
        .o_sched       (sched)
    );

    pms_peer_unit #(
        .OWN_PORT_NUMBER (OWN_PORT_NUMBER)
    ) u_peer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_pd_fire  (pd_fire),
        .i_e2e      (e2e),
        .i_p2p      (p2p),
        .i_item     (r_in),
        .i_pd_seq   (pd_seq_cur),
        .i_own_id   (r_own_id),
        .i_reload   (r_reload),
        .i_qual     (r_qual),
        .o_est_next (est_next),
        .o_peer     (peer)
    );

    // result register: load on advance, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv) begin
            r_ov <= 1'b1;
        end else if (o_result.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sched <= sched;
            r_peer  <= peer;
        end
    end

    assign o_result.valid             = r_ov;
    assign o_result.send_pd_request   = r_sched.send_pd_request;
    assign o_result.pdelay_sequence   = r_sched.pdelay_sequence;
    assign o_result.send_sync         = r_sched.send_sync;
    assign o_result.sync_sequence     = r_sched.sync_sequence;
    assign o_result.send_announce     = r_sched.send_announce;
    assign o_result.announce_sequence = r_sched.announce_sequence;
    assign o_result.send_dly_response = r_peer.send_dly_response;
    assign o_result.slave_state       = r_peer.slave_state;
    assign o_result.path_delay_due    = r_peer.path_delay_due;
    assign o_result.one_step_response = r_peer.one_step_response;
    assign o_result.accepted          = r_peer.accepted;

    // a held word that does not advance stays held
    a_hold_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_iv && !adv) |=> r_iv)
        else $error("held word lost");

    // a tick never yields an accepted message
    a_tick_not_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && (r_sched.send_sync || r_sched.send_announce
                  || r_sched.send_pd_request)) |-> !r_peer.accepted)
        else $error("transmit request and acceptance in one word");

    // one-step flag only with a due path delay computation
    a_one_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_peer.one_step_response) |-> r_peer.path_delay_due)
        else $error("one-step without path delay");

    // peer delay requests only in peer mode
    a_pdelay_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_sched.send_pd_request) |-> (r_mode == MODE_P2P))
        else $error("peer delay request outside peer mode");

endmodule

`default_nettype wire

// ===== bench/schedule_checker.sv =====
`timescale 1ns / 1ps

// Passive scoreboard for the master port scheduler: mirrors the register
// writes, predicts one result word per accepted input word and compares
// the result words in order.
module schedule_checker
    import pms_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pms_item_if       item_bus,
    pms_cfg_if        cfg_bus,
    pms_result_if     result_bus,
    output int        o_outstanding,
    output int        o_mismatches
);

    localparam logic [15:0] OWN_PORT     = 16'(DEF_OWN_PORT_NUMBER);
    localparam int          REPORT_LIMIT = 10;

    typedef struct packed {
        t_sched sched;
        t_peer  peer;
    } t_sched_word;

    // register copy
    logic [1:0]  mode_r;
    logic [15:0] sync_period;
    logic [15:0] ann_period;
    logic [15:0] pdelay_period;
    logic        gate_r;
    logic [63:0] own_id;
    logic [7:0]  dropout_reload;
    logic [7:0]  qual_count;

    // port state copy
    logic [1:0]  peer_state;
    logic [63:0] peer_id;
    logic [7:0]  dropout_left;
    logic [8:0]  report_tally;
    logic        awaiting_fup;
    logic [15:0] pdelay_timer;
    logic [15:0] sync_timer;
    logic [15:0] ann_timer;
    logic [15:0] pdelay_seq;
    logic [15:0] sync_seq;
    logic [15:0] ann_seq;

    t_sched_word predicted_words[$];
    int          mismatches;

    function automatic logic period_reached(input logic [15:0] timer,
                                            input logic [15:0] period);
        return ({1'b0, timer} + 17'd1) >= {1'b0, period};
    endfunction

    // peer tracker: first report makes a candidate, same peer qualifies,
    // another peer drops the tracked one
    function automatic void note_report(input logic [63:0] id);
        logic [8:0] cap;
        logic [8:0] inc;
        cap = {1'b0, qual_count} + 9'd1;
        inc = report_tally + 9'd1;
        if (peer_state == PEER_NONE) begin
            report_tally = '0;
            dropout_left = dropout_reload;
            peer_id      = id;
            peer_state   = PEER_CANDIDATE;
        end else if (peer_id == id) begin
            dropout_left = dropout_reload;
            report_tally = (inc < cap) ? inc : cap;
            if (report_tally > {1'b0, qual_count}) begin
                peer_state = PEER_ESTABLISHED;
            end
        end else begin
            peer_state   = PEER_NONE;
            peer_id      = '0;
            dropout_left = '0;
            report_tally = '0;
        end
    endfunction

    function automatic t_sched_word step_schedule(input t_item w);
        t_sched_word r;
        logic        info_en;
        logic        checks_ok;
        r = '0;
        case (w.op)
            OP_TICK: begin
                if (mode_r == MODE_E2E || mode_r == MODE_P2P) begin
                    if (mode_r == MODE_P2P) begin
                        if (period_reached(pdelay_timer, pdelay_period)) begin
                            pdelay_timer = '0;
                            if (dropout_left != 0) begin
                                dropout_left = dropout_left - 8'd1;
                            end
                            if (dropout_left == 0) begin
                                peer_state = PEER_NONE;
                                peer_id    = '0;
                            end
                            pdelay_seq = pdelay_seq + 16'd1;
                            r.sched.send_pd_request = 1'b1;
                        end else begin
                            pdelay_timer = pdelay_timer + 16'd1;
                        end
                    end
                    info_en = (mode_r == MODE_E2E) || (peer_state == PEER_ESTABLISHED) ||
                              !gate_r;
                    if (info_en) begin
                        if (period_reached(sync_timer, sync_period)) begin
                            sync_timer = '0;
                            r.sched.send_sync     = 1'b1;
                            r.sched.sync_sequence = sync_seq;
                            sync_seq = sync_seq + 16'd1;
                        end else begin
                            sync_timer = sync_timer + 16'd1;
                        end
                        if (period_reached(ann_timer, ann_period)) begin
                            ann_timer = '0;
                            r.sched.send_announce     = 1'b1;
                            r.sched.announce_sequence = ann_seq;
                            ann_seq = ann_seq + 16'd1;
                        end else begin
                            ann_timer = ann_timer + 16'd1;
                        end
                    end
                end
            end
            OP_E2E_REQ: begin
                if (mode_r == MODE_E2E) begin
                    r.peer.send_dly_response = 1'b1;
                    r.peer.accepted          = 1'b1;
                end
            end
            default: begin
                checks_ok = (w.op != OP_PEER_RESP || w.request_timestamp_ready) &&
                            w.requester_clock_identity == own_id &&
                            w.requester_port == OWN_PORT &&
                            w.sequence_number == pdelay_seq;
                if (mode_r == MODE_P2P && checks_ok) begin
                    if (w.op == OP_PEER_RESP) begin
                        r.peer.accepted = 1'b1;
                        if (!w.twostep) begin
                            note_report(w.sender_clock_identity);
                            if (peer_state != PEER_NONE) begin
                                r.peer.path_delay_due    = 1'b1;
                                r.peer.one_step_response = 1'b1;
                            end
                        end else begin
                            awaiting_fup = 1'b1;
                        end
                    end else if (awaiting_fup) begin
                        r.peer.accepted = 1'b1;
                        awaiting_fup    = 1'b0;
                        if (peer_state != PEER_NONE) begin
                            r.peer.path_delay_due = 1'b1;
                        end
                        note_report(w.sender_clock_identity);
                    end
                end
            end
        endcase
        r.sched.pdelay_sequence = pdelay_seq;
        r.peer.slave_state      = peer_state;
        return r;
    endfunction

    function automatic string format_word(input t_sched_word w);
        return $sformatf({"pdreq=%0b/%0d sync=%0b/%0d ann=%0b/%0d dresp=%0b",
                          " slave=%0d due=%0b onestep=%0b acc=%0b"},
                         w.sched.send_pd_request, w.sched.pdelay_sequence,
                         w.sched.send_sync, w.sched.sync_sequence,
                         w.sched.send_announce, w.sched.announce_sequence,
                         w.peer.send_dly_response, w.peer.slave_state,
                         w.peer.path_delay_due, w.peer.one_step_response, w.peer.accepted);
    endfunction

    always @(posedge i_clk) begin : watch
        t_item       word;
        t_sched_word want;
        t_sched_word got;
        if (!i_rst_n) begin
            mode_r         = MODE_OFF;
            sync_period    = 16'd1;
            ann_period     = 16'd1;
            pdelay_period  = 16'd1;
            gate_r         = 1'b0;
            own_id         = '0;
            dropout_reload = 8'd3;
            qual_count     = 8'd3;
            peer_state     = PEER_NONE;
            peer_id        = '0;
            dropout_left   = '0;
            report_tally   = '0;
            awaiting_fup   = 1'b0;
            pdelay_timer   = '0;
            sync_timer     = '0;
            ann_timer      = '0;
            pdelay_seq     = '0;
            sync_seq       = '0;
            ann_seq        = '0;
            mismatches     = 0;
            predicted_words.delete();
        end else begin
            if (result_bus.valid && result_bus.ready) begin
                got.sched.send_pd_request   = result_bus.send_pd_request;
                got.sched.pdelay_sequence   = result_bus.pdelay_sequence;
                got.sched.send_sync         = result_bus.send_sync;
                got.sched.sync_sequence     = result_bus.sync_sequence;
                got.sched.send_announce     = result_bus.send_announce;
                got.sched.announce_sequence = result_bus.announce_sequence;
                got.peer.send_dly_response  = result_bus.send_dly_response;
                got.peer.slave_state        = result_bus.slave_state;
                got.peer.path_delay_due     = result_bus.path_delay_due;
                got.peer.one_step_response  = result_bus.one_step_response;
                got.peer.accepted           = result_bus.accepted;
                if (predicted_words.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("%0t: result word with none predicted: %s",
                                 $realtime, format_word(got));
                    end
                end else begin
                    want = predicted_words.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT) begin
                            $display("%0t: result word mismatch", $realtime);
                            $display("  expected %s", format_word(want));
                            $display("  actual   %s", format_word(got));
                        end
                    end
                end
            end
            if (cfg_bus.valid && cfg_bus.ready) begin
                case (cfg_bus.index)
                    CFG_MODE:          mode_r         = cfg_bus.data[1:0];
                    CFG_SYNC_PERIOD:   sync_period    = cfg_bus.data[15:0];
                    CFG_ANN_PERIOD:    ann_period     = cfg_bus.data[15:0];
                    CFG_PDELAY_PERIOD: pdelay_period  = cfg_bus.data[15:0];
                    CFG_SYNC_GATE:     gate_r         = cfg_bus.data[0];
                    CFG_OWN_ID:        own_id         = cfg_bus.data;
                    CFG_DROPOUT:       dropout_reload = cfg_bus.data[7:0];
                    CFG_QUAL:          qual_count     = cfg_bus.data[7:0];
                    default: begin
                    end
                endcase
            end
            if (item_bus.valid && item_bus.ready) begin
                word.op                       = item_bus.op;
                word.sender_clock_identity    = item_bus.sender_clock_identity;
                word.requester_clock_identity = item_bus.requester_clock_identity;
                word.requester_port           = item_bus.requester_port;
                word.sequence_number          = item_bus.sequence_number;
                word.twostep                  = item_bus.twostep;
                word.request_timestamp_ready  = item_bus.request_timestamp_ready;
                predicted_words.push_back(step_schedule(word));
            end
        end
        o_outstanding <= predicted_words.size();
        o_mismatches  <= mismatches;
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

// Top of the scheduler bench: clock, reset, stimulus and verdict. Checking
// lives in schedule_checker, which sits beside the block on the same buses.
module tb;
    import pms_pkg::*;

    // mode code with no name in the package; the port treats it as disabled
    localparam logic [1:0]  MODE_UNUSED   = 2'd3;
    localparam logic [15:0] OWN_PORT      = 16'(DEF_OWN_PORT_NUMBER);
    localparam int          RANDOM_PHASES = 11;
    localparam int          PHASE_WORDS   = 130;
    localparam int          HOLD_AT_WORD  = 700;
    localparam int          HOLD_CYCLES   = 200;
    localparam int          CYCLE_LIMIT   = 200_000;
    localparam logic [63:0] PEER_A        = 64'hA5A5_0000_0000_0001;
    localparam logic [63:0] PEER_B        = 64'h5A5A_FFFF_0000_0002;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] sync_period;
        logic [15:0] announce_period;
        logic [15:0] pdelay_period;
        logic        gate;
        logic [63:0] own_id;
        logic [7:0]  dropout;
        logic [7:0]  qual;
    } t_port_setup;

    logic i_clk;
    logic i_rst_n;

    pms_item_if   item_bus();
    pms_cfg_if    cfg_bus();
    pms_result_if result_bus();

    int outstanding;
    int mismatches;
    int words_sent;
    int cycle_count;
    bit idle_on;
    bit hold_off;

    // Track what the next well-formed response must carry: the last
    // written setup and the peer delay request sequence, which only ticks
    // in peer mode advance.
    t_port_setup cur_setup;
    logic [15:0] pd_timer;
    logic [15:0] pd_seq;
    logic [63:0] peer_ids[3];

    ptp_master_message_scheduler_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_bus),
        .i_cfg    (cfg_bus),
        .o_result (result_bus)
    );

    schedule_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .item_bus      (item_bus),
        .cfg_bus       (cfg_bus),
        .result_bus    (result_bus),
        .o_outstanding (outstanding),
        .o_mismatches  (mismatches)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Offer one word after a random gap. Keep valid high across back-to-back
    // words; drop it only when a gap is taken.
    task automatic offer_word(input t_item w);
        int gap;
        gap = idle_on ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_bus.valid                    <= 1'b1;
        item_bus.op                       <= w.op;
        item_bus.sender_clock_identity    <= w.sender_clock_identity;
        item_bus.requester_clock_identity <= w.requester_clock_identity;
        item_bus.requester_port           <= w.requester_port;
        item_bus.sequence_number          <= w.sequence_number;
        item_bus.twostep                  <= w.twostep;
        item_bus.request_timestamp_ready  <= w.request_timestamp_ready;
        @(posedge i_clk);
        while (!item_bus.ready) @(posedge i_clk);
        words_sent++;
        // advance the peer delay request sequence the same way the port does
        if (w.op == OP_TICK && cur_setup.mode == MODE_P2P) begin
            if ({1'b0, pd_timer} + 17'd1 >= {1'b0, cur_setup.pdelay_period}) begin
                pd_timer = '0;
                pd_seq   = pd_seq + 16'd1;
            end else begin
                pd_timer = pd_timer + 16'd1;
            end
        end
    endtask

    // Hold valid high across consecutive writes; the caller drops it.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
    endtask

    // Wait until every predicted word has come back, then let the two-stage
    // pipeline settle.
    task automatic drain_results();
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Drop the input, drain, then write every register of the new setup.
    task automatic apply_settings(input t_port_setup s);
        item_bus.valid <= 1'b0;
        drain_results();
        write_reg(CFG_MODE,          64'(s.mode));
        write_reg(CFG_SYNC_PERIOD,   64'(s.sync_period));
        write_reg(CFG_ANN_PERIOD,    64'(s.announce_period));
        write_reg(CFG_PDELAY_PERIOD, 64'(s.pdelay_period));
        write_reg(CFG_SYNC_GATE,     64'(s.gate));
        write_reg(CFG_OWN_ID,        s.own_id);
        write_reg(CFG_DROPOUT,       64'(s.dropout));
        write_reg(CFG_QUAL,          64'(s.qual));
        cfg_bus.valid <= 1'b0;
        cur_setup = s;
    endtask

    function automatic t_item random_word();
        t_item w;
        w.op                       = 2'($urandom);
        w.sender_clock_identity    = {$urandom, $urandom};
        w.requester_clock_identity = {$urandom, $urandom};
        w.requester_port           = 16'($urandom);
        w.sequence_number          = 16'($urandom);
        w.twostep                  = 1'($urandom);
        w.request_timestamp_ready  = 1'($urandom);
        return w;
    endfunction

    // tick with random junk in the fields it does not use
    function automatic t_item tick_word();
        t_item w;
        w    = random_word();
        w.op = OP_TICK;
        return w;
    endfunction

    // response that matches our identity, port and the current request
    function automatic t_item response_word(input logic [1:0] op, input logic [63:0] sender,
                                            input logic twostep);
        t_item w;
        w.op                       = op;
        w.sender_clock_identity    = sender;
        w.requester_clock_identity = cur_setup.own_id;
        w.requester_port           = OWN_PORT;
        w.sequence_number          = pd_seq;
        w.twostep                  = twostep;
        w.request_timestamp_ready  = 1'b1;
        return w;
    endfunction

    // nearly valid response with one thing wrong
    function automatic t_item broken_word(input logic [63:0] sender);
        t_item w;
        w = response_word($urandom_range(0, 1) ? OP_PEER_RESP : OP_PEER_FUP,
                          sender, 1'($urandom));
        case ($urandom_range(0, 3))
            0: w.sequence_number ^= 16'($urandom_range(1, 65535));
            1: w.requester_port  ^= 16'($urandom_range(1, 65535));
            2: w.requester_clock_identity ^= 64'd1 << $urandom_range(0, 63);
            default: w.request_timestamp_ready = 1'b0;
        endcase
        return w;
    endfunction

    function automatic logic [15:0] pick_period();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'd1;
            2: return 16'hFFFF;
            default: return 16'($urandom_range(2, 6));
        endcase
    endfunction

    function automatic t_port_setup random_setup(input int phase);
        t_port_setup s;
        case (phase % 6)
            1: s.mode = MODE_E2E;
            3: s.mode = MODE_OFF;
            5: s.mode = MODE_UNUSED;
            default: s.mode = MODE_P2P;
        endcase
        s.sync_period     = pick_period();
        s.announce_period = pick_period();
        s.pdelay_period   = pick_period();
        s.gate            = 1'($urandom);
        s.own_id          = {$urandom, $urandom};
        s.dropout         = 8'($urandom_range(1, 6));
        s.qual            = 8'($urandom_range(0, 4));
        if (phase == 2) begin
            // all registers but the mode at their low end
            s.sync_period     = '0;
            s.announce_period = '0;
            s.pdelay_period   = '0;
            s.gate            = 1'b0;
            s.own_id          = '0;
            s.dropout         = '0;
            s.qual            = '0;
        end else if (phase == 4) begin
            // all registers but the mode at their high end
            s.sync_period     = '1;
            s.announce_period = '1;
            s.pdelay_period   = '1;
            s.gate            = 1'b1;
            s.own_id          = '1;
            s.dropout         = '1;
            s.qual            = '1;
        end else if (phase == 8) begin
            // long dropout with instant qualification: stay established
            s.pdelay_period = 16'($urandom_range(2, 4));
            s.dropout       = '1;
            s.qual          = '0;
        end
        return s;
    endfunction

    // Peer mode traffic: mostly well-formed exchanges from the main peer,
    // some from rival peers, plus broken and random words.
    task automatic p2p_step();
        int          pick;
        logic [63:0] peer;
        pick = $urandom_range(0, 99);
        peer = ($urandom_range(0, 9) < 8) ? peer_ids[0] : peer_ids[$urandom_range(1, 2)];
        if (pick < 35) begin
            offer_word(tick_word());
        end else if (pick < 62) begin
            offer_word(response_word(OP_PEER_RESP, peer, 1'b0));
        end else if (pick < 80) begin
            offer_word(response_word(OP_PEER_RESP, peer, 1'b1));
            if ($urandom_range(0, 3) == 0) begin
                offer_word(tick_word());
            end
            offer_word(response_word(OP_PEER_FUP, peer, 1'b1));
        end else if (pick < 92) begin
            offer_word(broken_word(peer));
        end else begin
            offer_word(random_word());
        end
    endtask

    // Sink side: stall a random number of cycles before each result word,
    // and hold off entirely while the long stall is on.
    initial begin : result_sink
        int stall;
        result_bus.ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            stall = idle_on ? $urandom_range(0, 7) : 0;
            if (stall > 0 || hold_off) begin
                result_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
                while (hold_off) @(posedge i_clk);
            end
            result_bus.ready <= 1'b1;
            @(posedge i_clk);
            while (!result_bus.valid) @(posedge i_clk);
        end
    end

    // One long receiver stall in mid run: the sender keeps offering, so the
    // block fills and backs up its input.
    initial begin : long_hold
        hold_off <= 1'b0;
        while (words_sent < HOLD_AT_WORD) @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : stimulus
        t_port_setup s;
        t_item       w;
        int          phase_end;
        int          next_idle_flip;
        int          pick;

        i_rst_n                           <= 1'b0;
        idle_on                           <= 1'b1;
        item_bus.valid                    <= 1'b0;
        item_bus.op                       <= OP_TICK;
        item_bus.sender_clock_identity    <= '0;
        item_bus.requester_clock_identity <= '0;
        item_bus.requester_port           <= '0;
        item_bus.sequence_number          <= '0;
        item_bus.twostep                  <= 1'b0;
        item_bus.request_timestamp_ready  <= 1'b0;
        cfg_bus.valid                     <= 1'b0;
        cfg_bus.index                     <= CFG_MODE;
        cfg_bus.data                      <= '0;
        words_sent = 0;
        pd_timer   = '0;
        pd_seq     = '0;
        cur_setup  = '{mode: MODE_OFF, sync_period: 16'd1, announce_period: 16'd1,
                       pdelay_period: 16'd1, gate: 1'b0, own_id: '0,
                       dropout: 8'd3, qual: 8'd3};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Disabled after reset: nothing is sent, nothing accepted.
        offer_word(tick_word());
        w    = random_word();
        w.op = OP_E2E_REQ;
        offer_word(w);
        offer_word(response_word(OP_PEER_RESP, PEER_A, 1'b0));

        // End-to-end: Sync on every tick, Announce every other tick,
        // delay requests answered, peer messages ignored.
        s = '{mode: MODE_E2E, sync_period: 16'd0, announce_period: 16'd2,
              pdelay_period: 16'hFFFF, gate: 1'b1, own_id: '1, dropout: 8'd3, qual: 8'd3};
        apply_settings(s);
        repeat (3) offer_word(tick_word());
        w = '{op: OP_E2E_REQ, sender_clock_identity: '1, requester_clock_identity: '1,
              requester_port: '1, sequence_number: '1, twostep: 1'b1,
              request_timestamp_ready: 1'b1};
        offer_word(w);
        w = '{op: OP_E2E_REQ, sender_clock_identity: '0, requester_clock_identity: '0,
              requester_port: '0, sequence_number: '0, twostep: 1'b0,
              request_timestamp_ready: 1'b0};
        offer_word(w);
        offer_word(response_word(OP_PEER_RESP, PEER_A, 1'b0));

        // Peer mode with Sync/Announce gated on an established slave.
        s = '{mode: MODE_P2P, sync_period: 16'd1, announce_period: 16'd1,
              pdelay_period: 16'd2, gate: 1'b1, own_id: 64'h0123_4567_89AB_CDEF,
              dropout: 8'd2, qual: 8'd0};
        apply_settings(s);
        offer_word(tick_word());
        offer_word(tick_word());
        // one-step response: candidate, path delay due
        offer_word(response_word(OP_PEER_RESP, PEER_A, 1'b0));
        // request timestamp not ready: drop
        w = response_word(OP_PEER_RESP, PEER_A, 1'b0);
        w.request_timestamp_ready = 1'b0;
        offer_word(w);
        // follow-up with none awaited: drop
        offer_word(response_word(OP_PEER_FUP, PEER_A, 1'b1));
        // two-step exchange qualifies the same peer
        offer_word(response_word(OP_PEER_RESP, PEER_A, 1'b1));
        offer_word(response_word(OP_PEER_FUP, PEER_A, 1'b1));
        // established: Sync and Announce go out now
        offer_word(tick_word());
        offer_word(tick_word());
        // port, sequence and identity mismatches
        w = response_word(OP_PEER_RESP, PEER_A, 1'b0);
        w.requester_port = ~OWN_PORT;
        offer_word(w);
        w = response_word(OP_PEER_RESP, PEER_A, 1'b0);
        w.sequence_number = pd_seq + 16'd1;
        offer_word(w);
        w = response_word(OP_PEER_RESP, PEER_A, 1'b0);
        w.requester_clock_identity = ~cur_setup.own_id;
        offer_word(w);
        // delay request outside end-to-end: drop
        w    = random_word();
        w.op = OP_E2E_REQ;
        offer_word(w);
        // a different peer answers: tracked slave is dropped
        offer_word(response_word(OP_PEER_RESP, PEER_B, 1'b0));

        // Random phases, one setup each; idling is redrawn every 40 words.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            apply_settings(random_setup(p));
            peer_ids[0] = {$urandom, $urandom};
            peer_ids[1] = {$urandom, $urandom};
            peer_ids[2] = {$urandom, $urandom};
            phase_end      = words_sent + PHASE_WORDS;
            next_idle_flip = words_sent;
            while (words_sent < phase_end) begin
                if (words_sent >= next_idle_flip) begin
                    idle_on <= ($urandom_range(0, 9) < 7);
                    next_idle_flip = words_sent + 40;
                end
                if (cur_setup.mode == MODE_P2P) begin
                    p2p_step();
                end else if (cur_setup.mode == MODE_E2E) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 45) begin
                        offer_word(tick_word());
                    end else if (pick < 80) begin
                        w    = random_word();
                        w.op = OP_E2E_REQ;
                        offer_word(w);
                    end else begin
                        offer_word(random_word());
                    end
                end else begin
                    // disabled: anything goes, nothing should happen
                    offer_word(($urandom_range(0, 9) < 4) ? tick_word() : random_word());
                end
            end
        end

        item_bus.valid <= 1'b0;
        drain_results();
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
